// ===== src/tdl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdl_pkg
// Types, codes and constants shared by the track direction and length block.
// ----------------------------------------------------------------------------
package tdl_pkg;

	localparam logic signed [15:0] MIN_START_RST = 16'sd8000;
	localparam logic signed [15:0] MAX_START_RST = -16'sd8000;

	typedef enum logic [1:0] {
		CMD_COMBINED = 2'd0,
		CMD_XZ       = 2'd1,
		CMD_YZ       = 2'd2,
		CMD_END      = 2'd3
	} cmd_t;

	typedef enum logic {
		REG_MIN_START = 1'b0,
		REG_MAX_START = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic signed [15:0] coord;
		logic signed [15:0] depth_raw;
		logic [23:0]        energy;
	} in_item_t;

	typedef struct packed {
		logic [15:0]        direction;
		logic               upward;
		logic               degenerate;
		logic signed [15:0] begin_x;
		logic signed [15:0] begin_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
		logic [17:0]        track_length;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SQ,
		ST_LOAD,
		ST_ITER,
		ST_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic hit;
		logic prep;
		logic sq;
		logic start_iter;
		logic iter;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic iter_done;
	} dp_stat_t;

endpackage
`default_nettype wire

// ===== src/tdl_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdl_datapath
// Event accumulators, end-of-event divider and integer square root unit.
// ----------------------------------------------------------------------------
module tdl_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  tdl_pkg::in_item_t   item,
	input  tdl_pkg::dp_cmd_t    dcmd,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire [15:0]          cfg_data,
	output tdl_pkg::dp_stat_t   stat,
	output tdl_pkg::out_item_t  result
);
	import tdl_pkg::*;

	logic signed [15:0] min_start_q, max_start_q;
	logic               seen_q;
	logic signed [15:0] span_max_q, span_min_q, peak_depth_q;
	logic [23:0]        peak_energy_q;
	logic signed [15:0] xz_min_q, xz_max_q, yz_min_q, yz_max_q;
	logic signed [15:0] x_min_q, x_max_q, y_min_q, y_max_q;

	logic signed [15:0] depth;
	assign depth = (item.depth_raw == -16'sd32768) ? 16'sd32767 : -item.depth_raw;

	// End-of-event working registers.
	logic               degen_q, up_q;
	logic [16:0]        num_q, den_q;
	logic signed [15:0] bx_q, by_q, ex_q, ey_q;
	logic [16:0]        dx_q, dy_q, dz_q;
	logic [35:0]        sum_q;
	logic [4:0]         cnt_q;
	// Restoring divider.
	logic [17:0]        rem_q;
	logic [15:0]        quo_q;
	// Square root, one result bit per iteration.
	logic [35:0]        rad_q;
	logic [19:0]        sroot_q;
	logic [19:0]        srem_q;

	logic signed [16:0] num_w, den_w, dxw, dyw, dzw;
	logic signed [15:0] bx_w, by_w, ex_w, ey_w, zhi, zlo;
	logic               up_w;
	logic [17:0]        rem_sh;
	logic [19:0]        srem_sh, trial;

	always_comb begin
		den_w = 17'(span_max_q) - 17'(span_min_q);
		num_w = 17'(peak_depth_q) - 17'(span_min_q);
		up_w  = ($signed({num_w, 1'b0}) >= $signed({den_w[16], den_w}));
		bx_w  = up_w ? x_min_q : x_max_q;
		by_w  = up_w ? y_min_q : y_max_q;
		ex_w  = up_w ? x_max_q : x_min_q;
		ey_w  = up_w ? y_max_q : y_min_q;
		zhi   = (xz_max_q > yz_max_q) ? xz_max_q : yz_max_q;
		zlo   = (xz_min_q < yz_min_q) ? xz_min_q : yz_min_q;
		dxw   = 17'(bx_w) - 17'(ex_w);
		dyw   = 17'(by_w) - 17'(ey_w);
		dzw   = 17'(zhi) - 17'(zlo);
		rem_sh  = {rem_q[16:0], 1'b0};
		srem_sh = {srem_q[17:0], rad_q[35:34]};
		trial   = {sroot_q[17:0], 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_start_q <= MIN_START_RST;
			max_start_q <= MAX_START_RST;
			seen_q <= 1'b0;
			span_max_q <= '0; span_min_q <= '0; peak_depth_q <= '0; peak_energy_q <= '0;
			xz_min_q <= MIN_START_RST; yz_min_q <= MIN_START_RST;
			xz_max_q <= MAX_START_RST; yz_max_q <= MAX_START_RST;
			x_min_q <= '0; x_max_q <= '0; y_min_q <= '0; y_max_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MIN_START) begin
					min_start_q <= cfg_data; xz_min_q <= cfg_data; yz_min_q <= cfg_data;
				end else begin
					max_start_q <= cfg_data; xz_max_q <= cfg_data; yz_max_q <= cfg_data;
				end
			end
			if (dcmd.hit) begin
				case (cmd_t'(item.cmd))
					CMD_COMBINED: begin
						seen_q <= 1'b1;
						if (!seen_q || depth > span_max_q) span_max_q <= depth;
						if (!seen_q || depth < span_min_q) span_min_q <= depth;
						if (item.energy > peak_energy_q) begin
							peak_energy_q <= item.energy; peak_depth_q <= depth;
						end
					end
					CMD_XZ: begin
						if (depth > xz_max_q) begin xz_max_q <= depth; x_max_q <= item.coord; end
						if (depth < xz_min_q) begin xz_min_q <= depth; x_min_q <= item.coord; end
					end
					CMD_YZ: begin
						if (depth > yz_max_q) begin yz_max_q <= depth; y_max_q <= item.coord; end
						if (depth < yz_min_q) begin yz_min_q <= depth; y_min_q <= item.coord; end
					end
					default: ;
				endcase
			end
			if (dcmd.start_iter) cnt_q <= 5'd18;
			else if (dcmd.iter && cnt_q != '0) cnt_q <= cnt_q - 5'd1;
			if (dcmd.finish) begin
				seen_q <= 1'b0;
				span_max_q <= '0; span_min_q <= '0; peak_depth_q <= '0; peak_energy_q <= '0;
				xz_min_q <= min_start_q; yz_min_q <= min_start_q;
				xz_max_q <= max_start_q; yz_max_q <= max_start_q;
				x_min_q <= '0; x_max_q <= '0; y_min_q <= '0; y_max_q <= '0;
			end
		end
	end

	// Payload registers of the end-of-event computation.
	always_ff @(posedge clk) begin
		if (dcmd.prep) begin
			degen_q <= (den_w <= 0);
			up_q <= up_w;
			num_q <= num_w; den_q <= den_w;
			bx_q <= bx_w; by_q <= by_w; ex_q <= ex_w; ey_q <= ey_w;
			dx_q <= dxw[16] ? 17'(-dxw) : dxw;
			dy_q <= dyw[16] ? 17'(-dyw) : dyw;
			// The sentinels can leave the depth extent negative.
			dz_q <= dzw[16] ? 17'(-dzw) : dzw;
		end
		if (dcmd.sq) begin
			sum_q <= 36'(34'(dx_q) * 34'(dx_q)) + 36'(34'(dy_q) * 34'(dy_q))
				+ 36'(34'(dz_q) * 34'(dz_q));
		end
		if (dcmd.start_iter) begin
			rem_q <= {1'b0, num_q}; quo_q <= '0;
			rad_q <= sum_q; sroot_q <= '0; srem_q <= '0;
		end else if (dcmd.iter) begin
			// Divider: 16 quotient bits in the last 16 of 18 iterations; the first two leave it unchanged.
			if (cnt_q <= 5'd16) begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= rem_sh - {1'b0, den_q}; quo_q <= {quo_q[14:0], 1'b1};
				end else begin
					rem_q <= rem_sh; quo_q <= {quo_q[14:0], 1'b0};
				end
			end
			rad_q <= {rad_q[33:0], 2'b00};
			if (srem_sh >= trial) begin
				srem_q <= srem_sh - trial; sroot_q <= {sroot_q[18:0], 1'b1};
			end else begin
				srem_q <= srem_sh; sroot_q <= {sroot_q[18:0], 1'b0};
			end
		end
	end

	assign stat.iter_done = (cnt_q == 5'd1);

	always_comb begin
		result = '0;
		result.degenerate = degen_q;
		if (!degen_q) begin
			if (num_q[16] || num_q == '0) result.direction = '0;
			else if (num_q >= den_q) result.direction = 16'hFFFF;
			else result.direction = quo_q;
			result.upward = up_q;
			result.begin_x = bx_q; result.begin_y = by_q;
			result.end_x = ex_q; result.end_y = ey_q;
			result.track_length = sroot_q[17:0];
		end
	end
endmodule
`default_nettype wire

// ===== src/tdl_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdl_ctrl
// Sequencer for hit accumulation and the end-of-event computation.
// ----------------------------------------------------------------------------
module tdl_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	input  wire [1:0]          in_cmd,
	input  wire                out_stall,
	input  tdl_pkg::dp_stat_t  stat,
	output logic               in_stall,
	output logic               out_valid,
	output tdl_pkg::dp_cmd_t   dcmd
);
	import tdl_pkg::*;

	state_t state_q, state_d;
	logic   acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		dcmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		acc = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				acc = in_valid;
				if (acc) begin
					if (in_cmd == CMD_END) state_d = ST_PREP;
					else dcmd.hit = 1'b1;
				end
			end
			ST_PREP: begin dcmd.prep = 1'b1; state_d = ST_SQ; end
			ST_SQ: begin dcmd.sq = 1'b1; state_d = ST_LOAD; end
			ST_LOAD: begin dcmd.start_iter = 1'b1; state_d = ST_ITER; end
			ST_ITER: begin
				dcmd.iter = 1'b1;
				if (stat.iter_done) begin dcmd.finish = 1'b1; state_d = ST_OUT; end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== src/track_direction_and_length_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Hit transactions are accepted back to back.
// An end-of-event result follows its accepted transaction through setup, squaring,
// load, then 18 square-root steps, the last 16 of which also give quotient bits.
// The result holds until taken; input is accepted again in the cycle after.
// Reset restores min_start 8000, max_start -8000 and clears the event state.
// ----------------------------------------------------------------------------
// track_direction_and_length_top
// Estimates track direction ratio, endpoints and length from one event's hits.
// ----------------------------------------------------------------------------
module track_direction_and_length_top (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  tdl_pkg::in_item_t   in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output tdl_pkg::out_item_t  out_data,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire [15:0]          cfg_data
);
	import tdl_pkg::*;

	dp_cmd_t  dcmd;
	dp_stat_t stat;

	tdl_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_cmd(in_data.cmd),
		.out_stall(out_stall), .stat(stat), .in_stall(in_stall),
		.out_valid(out_valid), .dcmd(dcmd)
	);

	tdl_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .item(in_data), .dcmd(dcmd),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.stat(stat), .result(out_data)
	);
endmodule
`default_nettype wire

// ===== verif/tb_track_direction_and_length_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_track_direction_and_length_top
// Drives events of detector hits into the track block and checks every
// event result against a behavioral model of depth span, endpoints and length.
// ----------------------------------------------------------------------------
module tb_track_direction_and_length_top;
	import tdl_pkg::*;

	class track_scoreboard;
		logic signed [15:0] min_start, max_start;
		bit seen_first;
		int span_max, span_min, peak_depth;
		int unsigned peak_energy;
		int xz_min, xz_max, yz_min, yz_max, x_lo, x_hi, y_lo, y_hi;
		out_item_t expected_results[$];
		int errors;
		int events;

		function void clear_event();
			seen_first = 0;
			span_max = 0;
			span_min = 0;
			peak_energy = 0;
			peak_depth = 0;
			xz_min = min_start;
			yz_min = min_start;
			xz_max = max_start;
			yz_max = max_start;
			x_lo = 0;
			x_hi = 0;
			y_lo = 0;
			y_hi = 0;
		endfunction

		function void reset_state();
			min_start = MIN_START_RST;
			max_start = MAX_START_RST;
			errors = 0;
			events = 0;
			clear_event();
		endfunction

		function void write_reg(reg_idx_t idx, logic [15:0] value);
			if (idx == REG_MIN_START) begin
				min_start = value;
				xz_min = min_start;
				yz_min = min_start;
			end else begin
				max_start = value;
				xz_max = max_start;
				yz_max = max_start;
			end
		endfunction

		function longint unsigned floor_sqrt(longint unsigned v);
			longint unsigned res, bitv;
			res = 0;
			bitv = 64'd1 << 62;
			while (bitv > v)
				bitv >>= 2;
			while (bitv != 0) begin
				if (v >= res + bitv) begin
					v -= res + bitv;
					res = (res >> 1) + bitv;
				end else begin
					res >>= 1;
				end
				bitv >>= 2;
			end
			return res;
		endfunction

		function void note_input(in_item_t it);
			int coord, depth, den, num, zhi, zlo, bx, by, ex, ey;
			longint dx, dy, dz;
			out_item_t r;
			coord = it.coord;
			depth = -int'(it.depth_raw);
			if (depth > 32767)
				depth = 32767;
			case (cmd_t'(it.cmd))
				CMD_COMBINED: begin
					if (!seen_first) begin
						span_max = depth;
						span_min = depth;
						seen_first = 1;
					end
					if (depth > span_max) span_max = depth;
					if (depth < span_min) span_min = depth;
					if (it.energy > peak_energy) begin
						peak_energy = it.energy;
						peak_depth = depth;
					end
				end
				CMD_XZ: begin
					if (depth > xz_max) begin xz_max = depth; x_hi = coord; end
					if (depth < xz_min) begin xz_min = depth; x_lo = coord; end
				end
				CMD_YZ: begin
					if (depth > yz_max) begin yz_max = depth; y_hi = coord; end
					if (depth < yz_min) begin yz_min = depth; y_lo = coord; end
				end
				default: begin
					r = '0;
					den = span_max - span_min;
					if (den <= 0) begin
						r.degenerate = 1;
					end else begin
						num = peak_depth - span_min;
						if (num <= 0)
							r.direction = 0;
						else if (num >= den)
							r.direction = 16'hFFFF;
						else
							r.direction = 16'((longint'(num) << 16) / den);
						r.upward = (longint'(num) * 2 >= den);
						if (r.upward) begin
							bx = x_lo; by = y_lo; ex = x_hi; ey = y_hi;
						end else begin
							bx = x_hi; by = y_hi; ex = x_lo; ey = y_lo;
						end
						r.begin_x = bx;
						r.begin_y = by;
						r.end_x = ex;
						r.end_y = ey;
						zhi = (xz_max > yz_max) ? xz_max : yz_max;
						zlo = (xz_min < yz_min) ? xz_min : yz_min;
						dx = bx - ex;
						dy = by - ey;
						dz = zhi - zlo;
						r.track_length = 18'(floor_sqrt(dx * dx + dy * dy + dz * dz));
					end
					expected_results.push_back(r);
					clear_event();
				end
			endcase
		endfunction

		function void check_result(out_item_t got);
			out_item_t e;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %p", $time, got);
				errors++;
				return;
			end
			e = expected_results.pop_front();
			events++;
			if (got.direction !== e.direction) report("direction", e.direction, got.direction);
			if (got.upward !== e.upward) report("upward", e.upward, got.upward);
			if (got.degenerate !== e.degenerate)
				report("degenerate", e.degenerate, got.degenerate);
			if (got.begin_x !== e.begin_x) report("begin_x", e.begin_x, got.begin_x);
			if (got.begin_y !== e.begin_y) report("begin_y", e.begin_y, got.begin_y);
			if (got.end_x !== e.end_x) report("end_x", e.end_x, got.end_x);
			if (got.end_y !== e.end_y) report("end_y", e.end_y, got.end_y);
			if (got.track_length !== e.track_length)
				report("track_length", e.track_length, got.track_length);
		endfunction

		function void report(string field, logic [31:0] exp_v, logic [31:0] act_v);
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_v, act_v);
			errors++;
		endfunction
	endclass

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 40;

	logic clk;
	logic arst_n;
	logic in_valid, in_stall;
	in_item_t in_data;
	logic out_valid, out_stall;
	out_item_t out_data;
	logic cfg_we;
	logic cfg_index;
	logic [15:0] cfg_data;

	track_scoreboard sb;
	int send_idle_pct, recv_idle_pct;
	int idle_cycles;
	int items_sent;
	bit timed_out;

	track_direction_and_length_top DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// Receiver: stall chosen per cycle, results checked at the rising edge.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("tb_track_direction_and_length_top failed");
			$finish;
		end
	end

	// Valid stays high after a transaction until the next item or an idle cycle.
	task automatic send_item(cmd_t cmd, logic [15:0] coord, logic [15:0] depth_raw,
			logic [23:0] energy);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		in_data <= {cmd, coord, depth_raw, energy};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_input({cmd, coord, depth_raw, energy});
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.expected_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Depth near the span so endpoints stay within interesting ranges.
	function automatic logic [15:0] rand_depth();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($urandom_range(1000) - 500);
			default: return 16'($urandom_range(16000) - 8000);
		endcase
	endfunction

	task automatic random_event();
		int hits;
		int kind;
		hits = $urandom_range(8);
		for (int i = 0; i < hits; i++) begin
			kind = $urandom_range(9);
			send_item(kind < 4 ? CMD_COMBINED : (kind < 7 ? CMD_XZ : CMD_YZ),
				16'($urandom), rand_depth(),
				($urandom_range(3) == 0) ? 24'($urandom_range(3)) : 24'($urandom));
		end
		send_item(CMD_END, 16'($urandom), 16'($urandom), 24'($urandom));
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		out_stall = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		items_sent = 0;
		idle_cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: empty event, lone combined hit, extremes, ties, clamping.
		send_item(CMD_END, 16'h0, 16'h0, 24'h0);
		send_item(CMD_COMBINED, 16'h0, 16'sh100, 24'h5);
		send_item(CMD_END, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		send_item(CMD_COMBINED, 16'h7FFF, 16'h8000, 24'hFFFFFF);
		send_item(CMD_COMBINED, 16'h8000, 16'h7FFF, 24'hFFFFFF);
		send_item(CMD_XZ, 16'h7FFF, 16'h8000, 24'h0);
		send_item(CMD_XZ, 16'h8000, 16'h7FFF, 24'h0);
		send_item(CMD_YZ, 16'h8000, 16'h8000, 24'h0);
		send_item(CMD_YZ, 16'h7FFF, 16'h7FFF, 24'h0);
		send_item(CMD_END, 16'h0, 16'h0, 24'h0);
		send_item(CMD_COMBINED, 16'h0, -16'sd100, 24'h10);
		send_item(CMD_COMBINED, 16'h0, 16'sd100, 24'h10);
		send_item(CMD_COMBINED, 16'h0, 16'sd0, 24'h20);
		send_item(CMD_XZ, 16'sd50, 16'sd20, 24'h0);
		send_item(CMD_YZ, -16'sd50, -16'sd20, 24'h0);
		send_item(CMD_END, 16'h0, 16'h0, 24'h0);
		send_item(CMD_COMBINED, 16'h0, 16'sd100, 24'h30);
		send_item(CMD_COMBINED, 16'h0, -16'sd100, 24'h8);
		send_item(CMD_END, 16'h0, 16'h0, 24'h0);
		wait_drained();

		write_reg(REG_MIN_START, 16'h7FFF);
		write_reg(REG_MAX_START, 16'h8000);
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 16 : (ph == 1) ? 59 : 0;
			recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 16 : 0;
			for (int k = 0; k < 2; k++) begin
				while (items_sent < 25 + (ph * 2 + k + 1) * 72)
					random_event();
				wait_drained();
				case ($urandom_range(2))
					0: begin
						write_reg(REG_MIN_START, MIN_START_RST);
						write_reg(REG_MAX_START, MAX_START_RST);
					end
					1: begin
						write_reg(REG_MIN_START, 16'h8000);
						write_reg(REG_MAX_START, 16'h7FFF);
					end
					default: begin
						write_reg(REG_MIN_START, 16'($urandom));
						write_reg(REG_MAX_START, 16'($urandom));
					end
				endcase
			end
		end
		wait_drained();

		$display("Sent %0d hit and end-of-event transactions; checked %0d event results.",
			items_sent, sb.events);
		$display("Covered three idling mixes and several sentinel register settings.");
		if (sb.errors == 0 && sb.expected_results.size() == 0)
			$display("tb_track_direction_and_length_top passed");
		else
			$display("tb_track_direction_and_length_top failed");
		$finish;
	end
endmodule
